### rtl/clx_pkg.sv
// clx_pkg: shared types, scan mode codes, token kinds, error codes and keyword tables
// for the c subset lexer. No dependencies.
package clx_pkg;

    // default position counter widths
    localparam int LINE_BITS_DEF   = 16;
    localparam int COLUMN_BITS_DEF = 12;

    // result queue depth, two free entries are needed to take a word
    localparam int QUEUE_DEPTH = 4;

    localparam int NKW = 21;

    // scan mode codes
    localparam logic [4:0] M_IDLE     = 5'd0;
    localparam logic [4:0] M_IDENT    = 5'd1;
    localparam logic [4:0] M_NUMBER   = 5'd2;
    localparam logic [4:0] M_OP1      = 5'd3;
    localparam logic [4:0] M_OP2      = 5'd4;
    localparam logic [4:0] M_SLASH    = 5'd5;
    localparam logic [4:0] M_LCOMM    = 5'd6;
    localparam logic [4:0] M_BCOMM    = 5'd7;
    localparam logic [4:0] M_BSTAR    = 5'd8;
    localparam logic [4:0] M_STR      = 5'd9;
    localparam logic [4:0] M_STR_ESC  = 5'd10;
    localparam logic [4:0] M_CH_OPEN  = 5'd11;
    localparam logic [4:0] M_CH_ESC   = 5'd12;
    localparam logic [4:0] M_CH_CLOSE = 5'd13;
    localparam logic [4:0] M_BSLASH   = 5'd14;
    localparam logic [4:0] M_DONE     = 5'd15;
    localparam logic [4:0] M_HALT     = 5'd16;

    // token kinds
    localparam logic [5:0] K_END    = 6'd0;
    localparam logic [5:0] K_IDENT  = 6'd1;
    localparam logic [5:0] K_NUMBER = 6'd2;
    localparam logic [5:0] K_CHAR   = 6'd3;
    localparam logic [5:0] K_STRING = 6'd4;
    localparam logic [5:0] K_OPER   = 6'd5;

    // error codes
    localparam logic [2:0] E_NONE      = 3'd0;
    localparam logic [2:0] E_OPEN_CMT  = 3'd1;
    localparam logic [2:0] E_BAD_ESC   = 3'd2;
    localparam logic [2:0] E_NO_CLOSE  = 3'd3;
    localparam logic [2:0] E_OPEN_STR  = 3'd4;
    localparam logic [2:0] E_STRAY_BS  = 3'd5;
    localparam logic [2:0] E_UNKNOWN   = 3'd6;

    // keyword spellings, right aligned: last char in the low byte
    localparam logic [63:0] KW_NAME [NKW] = '{
        64'("static"), 64'("extern"), 64'("void"), 64'("char"), 64'("int"),
        64'("long"), 64'("double"), 64'("unsigned"), 64'("struct"),
        64'("return"), 64'("if"), 64'("else"), 64'("for"), 64'("while"),
        64'("do"), 64'("continue"), 64'("break"), 64'("switch"), 64'("case"),
        64'("default"), 64'("sizeof")
    };
    localparam logic [3:0] KW_LEN [NKW] = '{
        4'd6, 4'd6, 4'd4, 4'd4, 4'd3, 4'd4, 4'd6, 4'd8, 4'd6, 4'd6, 4'd2,
        4'd4, 4'd3, 4'd5, 4'd2, 4'd8, 4'd5, 4'd6, 4'd4, 4'd7, 4'd6
    };
    localparam logic [5:0] KW_KIND [NKW] = '{
        6'd6, 6'd7, 6'd8, 6'd3, 6'd9, 6'd10, 6'd11, 6'd12, 6'd13, 6'd14,
        6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24,
        6'd5
    };

    // scanner state carried between words
    typedef struct packed {
        logic [4:0]  mode;
        logic [20:0] cand;
        logic [3:0]  len;
        logic [7:0]  hb;
        logic [5:0]  hk;
        logic        hv;
        logic        fp;
        logic [7:0]  opf;
    } t_state;

    // one result word without its position; at_cur picks current vs token position
    typedef struct packed {
        logic [7:0] value;
        logic       bvalid;
        logic [5:0] kind;
        logic       first;
        logic       last;
        logic [2:0] err;
        logic       at_cur;
    } t_item;

    function automatic t_item mk_item(logic [7:0] value, logic bvalid, logic [5:0] kind,
                                      logic first, logic last, logic [2:0] err,
                                      logic at_cur);
        t_item r;
        r.value  = value;
        r.bvalid = bvalid;
        r.kind   = kind;
        r.first  = first;
        r.last   = last;
        r.err    = err;
        r.at_cur = at_cur;
        return r;
    endfunction

endpackage

### rtl/clx_step.sv
// clx_step: next-state and result logic of the lexer for one source word.
// Depends on clx_pkg.
module clx_step (
    input  logic [7:0]      i_c,
    input  logic            i_eoi,
    input  clx_pkg::t_state i_st,
    output clx_pkg::t_state o_st,
    output clx_pkg::t_item  o_item0,
    output clx_pkg::t_item  o_item1,
    output logic [1:0]      o_cnt,
    output logic            o_set_tok,
    output logic            o_pos_step
);

    function automatic logic is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    // char of keyword k at position pos (pos below its length)
    function automatic logic [7:0] kw_char(int k, logic [2:0] pos);
        logic [3:0] idx;
        idx = clx_pkg::KW_LEN[k] - 4'd1 - {1'b0, pos};
        return clx_pkg::KW_NAME[k][{idx[2:0], 3'b000} +: 8];
    endfunction

    // narrow the candidate mask by one identifier char
    function automatic logic [20:0] kw_filter(logic [20:0] cand, logic [3:0] len,
                                              logic [7:0] c);
        logic [20:0] r;
        r = cand;
        if (len >= 4'd8) begin
            r = '0;
        end else begin
            for (int k = 0; k < clx_pkg::NKW; k++) begin
                if (clx_pkg::KW_LEN[k] <= len || kw_char(k, len[2:0]) != c) r[k] = 1'b0;
            end
        end
        return r;
    endfunction

    // first surviving keyword of matching length, else identifier
    function automatic logic [5:0] ident_kind(logic [20:0] cand, logic [3:0] len);
        logic [5:0] r;
        logic       hit;
        r = clx_pkg::K_IDENT;
        hit = 1'b0;
        for (int k = 0; k < clx_pkg::NKW; k++) begin
            if (!hit && cand[k] && clx_pkg::KW_LEN[k] == len) begin
                r = clx_pkg::KW_KIND[k];
                hit = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [5:0] punct_kind(logic [7:0] c);
        case (c)
            "(": return 6'd25;
            ")": return 6'd26;
            "[": return 6'd27;
            "]": return 6'd28;
            "{": return 6'd29;
            "}": return 6'd30;
            ",": return 6'd31;
            ";": return 6'd32;
            ":": return 6'd33;
            "#": return 6'd34;
            default: return clx_pkg::K_END;
        endcase
    endfunction

    // escape decode: {ok, byte}
    function automatic logic [8:0] decode_esc(logic [7:0] c);
        case (c)
            "\\": return {1'b1, 8'd92};
            "'":  return {1'b1, 8'd39};
            "\"": return {1'b1, 8'd34};
            "n":  return {1'b1, 8'd10};
            "r":  return {1'b1, 8'd13};
            "t":  return {1'b1, 8'd9};
            "b":  return {1'b1, 8'd8};
            "f":  return {1'b1, 8'd12};
            "v":  return {1'b1, 8'd11};
            "a":  return {1'b1, 8'd7};
            "0":  return {1'b1, 8'd0};
            default: return 9'd0;
        endcase
    endfunction

    always_comb begin
        logic            pa;
        logic [7:0]      pv;
        logic            fa;
        logic [5:0]      fk;
        logic [2:0]      ea;
        logic            ed;
        logic            clr;
        logic            start;
        logic            ext;
        logic [8:0]      esc;
        logic [7:0]      c;
        clx_pkg::t_state s;
        clx_pkg::t_item  x;

        c = i_c;
        s = i_st;
        o_item0 = '0;
        o_item1 = '0;
        o_cnt = 2'd0;
        o_set_tok = 1'b0;
        o_pos_step = 1'b0;
        pa = 1'b0;
        pv = c;
        fa = 1'b0;
        fk = clx_pkg::K_OPER;
        ea = clx_pkg::E_NONE;
        ed = 1'b0;
        clr = 1'b0;
        start = 1'b0;
        ext = 1'b0;
        esc = decode_esc(c);
        x = '0;

        // decide what the word does to the open token
        if (i_st.mode == clx_pkg::M_HALT) begin
            s = i_st;
        end else if (i_st.mode == clx_pkg::M_DONE) begin
            ed = i_eoi;
        end else if (i_eoi) begin
            case (i_st.mode)
                clx_pkg::M_IDENT: begin
                    fa = 1'b1;
                    fk = ident_kind(i_st.cand, i_st.len);
                    ed = 1'b1;
                end
                clx_pkg::M_NUMBER: begin
                    fa = 1'b1;
                    fk = clx_pkg::K_NUMBER;
                    ed = 1'b1;
                end
                clx_pkg::M_OP1, clx_pkg::M_OP2, clx_pkg::M_SLASH: begin
                    fa = 1'b1;
                    ed = 1'b1;
                end
                clx_pkg::M_BCOMM, clx_pkg::M_BSTAR: ea = clx_pkg::E_OPEN_CMT;
                clx_pkg::M_STR, clx_pkg::M_STR_ESC: ea = clx_pkg::E_OPEN_STR;
                clx_pkg::M_CH_OPEN, clx_pkg::M_CH_ESC, clx_pkg::M_CH_CLOSE:
                    ea = clx_pkg::E_NO_CLOSE;
                clx_pkg::M_BSLASH: ea = clx_pkg::E_STRAY_BS;
                default: ed = 1'b1;
            endcase
        end else begin
            o_pos_step = 1'b1;
            case (i_st.mode)
                clx_pkg::M_IDLE: start = 1'b1;
                clx_pkg::M_IDENT: begin
                    if (is_alpha(c) || is_digit(c) || c == "_") begin
                        s.cand = kw_filter(i_st.cand, i_st.len, c);
                        if (i_st.len != 4'd15) s.len = i_st.len + 4'd1;
                        pa = 1'b1;
                    end else begin
                        fa = 1'b1;
                        fk = ident_kind(i_st.cand, i_st.len);
                        start = 1'b1;
                    end
                end
                clx_pkg::M_NUMBER: begin
                    if (is_digit(c)) begin
                        pa = 1'b1;
                    end else begin
                        fa = 1'b1;
                        fk = clx_pkg::K_NUMBER;
                        start = 1'b1;
                    end
                end
                clx_pkg::M_OP1: begin
                    if ((i_st.opf == "<" || i_st.opf == ">") && c == i_st.opf) begin
                        pa = 1'b1;
                        s.mode = clx_pkg::M_OP2;
                    end else begin
                        if (i_st.opf == "<" || i_st.opf == ">") ext = (c == "=");
                        else if (i_st.opf == "+" || i_st.opf == "&" || i_st.opf == "|")
                            ext = (c == i_st.opf || c == "=");
                        else if (i_st.opf == "-") ext = (c == "-" || c == "=" || c == ">");
                        else ext = (c == "=");
                        pa = ext;
                        fa = 1'b1;
                        start = !ext;
                    end
                end
                clx_pkg::M_OP2: begin
                    pa = (c == "=");
                    fa = 1'b1;
                    start = (c != "=");
                end
                clx_pkg::M_SLASH: begin
                    if (c == "/" || c == "*") begin
                        clr = 1'b1;
                        s.mode = (c == "/") ? clx_pkg::M_LCOMM : clx_pkg::M_BCOMM;
                    end else begin
                        pa = (c == "=");
                        fa = 1'b1;
                        start = (c != "=");
                    end
                end
                clx_pkg::M_LCOMM: if (c == 8'd10) s.mode = clx_pkg::M_IDLE;
                clx_pkg::M_BCOMM: if (c == "*") s.mode = clx_pkg::M_BSTAR;
                clx_pkg::M_BSTAR: begin
                    if (c == "/") s.mode = clx_pkg::M_IDLE;
                    else if (c != "*") s.mode = clx_pkg::M_BCOMM;
                end
                clx_pkg::M_STR: begin
                    if (c == "\"") begin
                        fa = 1'b1;
                        fk = clx_pkg::K_STRING;
                    end else if (c == "\\") begin
                        s.mode = clx_pkg::M_STR_ESC;
                    end else begin
                        pa = 1'b1;
                    end
                end
                clx_pkg::M_STR_ESC: begin
                    if (c == 8'd10) begin
                        s.mode = clx_pkg::M_STR;
                    end else if (esc[8]) begin
                        pa = 1'b1;
                        pv = esc[7:0];
                        s.mode = clx_pkg::M_STR;
                    end else begin
                        ea = clx_pkg::E_BAD_ESC;
                    end
                end
                clx_pkg::M_CH_OPEN: begin
                    if (c == "\\") begin
                        s.mode = clx_pkg::M_CH_ESC;
                    end else begin
                        pa = 1'b1;
                        s.mode = clx_pkg::M_CH_CLOSE;
                    end
                end
                clx_pkg::M_CH_ESC: begin
                    if (c == 8'd10) begin
                        s.mode = clx_pkg::M_CH_OPEN;
                    end else if (esc[8]) begin
                        pa = 1'b1;
                        pv = esc[7:0];
                        s.mode = clx_pkg::M_CH_CLOSE;
                    end else begin
                        ea = clx_pkg::E_BAD_ESC;
                    end
                end
                clx_pkg::M_CH_CLOSE: begin
                    if (c == "'") begin
                        fa = 1'b1;
                        fk = clx_pkg::K_CHAR;
                    end else begin
                        ea = clx_pkg::E_NO_CLOSE;
                    end
                end
                clx_pkg::M_BSLASH: begin
                    if (c == 8'd10) s.mode = clx_pkg::M_IDLE;
                    else ea = clx_pkg::E_STRAY_BS;
                end
                default: begin
                    s.mode = clx_pkg::M_IDLE;
                    start = 1'b1;
                end
            endcase
        end

        // comment opener drops the held slash
        if (clr) begin
            s.hv = 1'b0;
            s.fp = 1'b0;
        end
        // push: release the held byte, hold the new one
        if (pa) begin
            if (s.hv) begin
                x = clx_pkg::mk_item(s.hb, 1'b1, s.hk, s.fp, 1'b0, clx_pkg::E_NONE, 1'b0);
                if (o_cnt == 2'd0) o_item0 = x; else o_item1 = x;
                o_cnt = o_cnt + 2'd1;
                s.fp = 1'b0;
            end
            s.hb = pv;
            s.hv = 1'b1;
        end
        // finish: last word of the token, or an empty one
        if (fa) begin
            if (s.hv) x = clx_pkg::mk_item(s.hb, 1'b1, fk, s.fp, 1'b1, clx_pkg::E_NONE, 1'b0);
            else x = clx_pkg::mk_item(8'd0, 1'b0, fk, 1'b1, 1'b1, clx_pkg::E_NONE, 1'b0);
            if (o_cnt == 2'd0) o_item0 = x; else o_item1 = x;
            o_cnt = o_cnt + 2'd1;
            s.hv = 1'b0;
            s.fp = 1'b0;
            s.mode = clx_pkg::M_IDLE;
        end
        // error word, then halt
        if (ea != clx_pkg::E_NONE) begin
            s.hv = 1'b0;
            s.fp = 1'b0;
            x = clx_pkg::mk_item(8'd0, 1'b0, clx_pkg::K_END, 1'b1, 1'b1, ea, 1'b1);
            if (o_cnt == 2'd0) o_item0 = x; else o_item1 = x;
            o_cnt = o_cnt + 2'd1;
            s.mode = clx_pkg::M_HALT;
        end
        // end of input word
        if (ed) begin
            x = clx_pkg::mk_item(8'd0, 1'b0, clx_pkg::K_END, 1'b1, 1'b1, clx_pkg::E_NONE, 1'b1);
            if (o_cnt == 2'd0) o_item0 = x; else o_item1 = x;
            o_cnt = o_cnt + 2'd1;
            s.mode = clx_pkg::M_DONE;
        end

        // start a new token from this byte
        if (start) begin
            s.mode = clx_pkg::M_IDLE;
            if (is_space(c)) begin
                s.mode = clx_pkg::M_IDLE;
            end else if (is_digit(c) || is_alpha(c) || c == "_" || c == "/" ||
                         c == "*" || c == "%" || c == "^" || c == "!" || c == "=" ||
                         c == "+" || c == "&" || c == "|" || c == "-" || c == "<" ||
                         c == ">") begin
                o_set_tok = 1'b1;
                s.fp = 1'b1;
                s.hb = c;
                s.hv = 1'b1;
                if (is_digit(c)) begin
                    s.hk = clx_pkg::K_NUMBER;
                    s.mode = clx_pkg::M_NUMBER;
                end else if (is_alpha(c) || c == "_") begin
                    s.hk = clx_pkg::K_IDENT;
                    s.cand = kw_filter('1, 4'd0, c);
                    s.len = 4'd1;
                    s.mode = clx_pkg::M_IDENT;
                end else if (c == "/") begin
                    s.hk = clx_pkg::K_OPER;
                    s.mode = clx_pkg::M_SLASH;
                end else begin
                    s.hk = clx_pkg::K_OPER;
                    s.opf = c;
                    s.mode = clx_pkg::M_OP1;
                end
            end else if (c == "'" || c == "\"") begin
                o_set_tok = 1'b1;
                s.fp = 1'b1;
                s.hv = 1'b0;
                s.hk = (c == "'") ? clx_pkg::K_CHAR : clx_pkg::K_STRING;
                s.mode = (c == "'") ? clx_pkg::M_CH_OPEN : clx_pkg::M_STR;
            end else if (c == "\\") begin
                s.mode = clx_pkg::M_BSLASH;
            end else if (c == "~" || c == "." || c == "?" || punct_kind(c) != clx_pkg::K_END)
            begin
                x = clx_pkg::mk_item(c, 1'b1,
                                     (punct_kind(c) != clx_pkg::K_END) ? punct_kind(c)
                                                                        : clx_pkg::K_OPER,
                                     1'b1, 1'b1, clx_pkg::E_NONE, 1'b1);
                if (o_cnt == 2'd0) o_item0 = x; else o_item1 = x;
                o_cnt = o_cnt + 2'd1;
            end else begin
                s.hv = 1'b0;
                s.fp = 1'b0;
                x = clx_pkg::mk_item(8'd0, 1'b0, clx_pkg::K_END, 1'b1, 1'b1,
                                     clx_pkg::E_UNKNOWN, 1'b1);
                if (o_cnt == 2'd0) o_item0 = x; else o_item1 = x;
                o_cnt = o_cnt + 2'd1;
                s.mode = clx_pkg::M_HALT;
            end
        end

        o_st = s;
    end

endmodule

### rtl/clx_queue.sv
// clx_queue: result queue, up to two words in per cycle, one out when ready.
// Depends on clx_pkg for its depth.
module clx_queue #(
    parameter int W = 40
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [1:0]   i_wr_cnt,
    input  logic [W-1:0] i_d0,
    input  logic [W-1:0] i_d1,
    output logic         o_room,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [W-1:0] o_data
);

    localparam int D  = clx_pkg::QUEUE_DEPTH;
    localparam int CW = $clog2(D + 1);

    logic [W-1:0]  r_q [D];
    logic [W-1:0]  n_q [D];
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic [CW-1:0] base;
    logic          pop;

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_q[0];
    assign o_room  = (r_cnt <= CW'(D - 2));
    assign pop     = o_valid && i_ready;
    assign base    = r_cnt - CW'(pop);

    // shift on read, then fill behind the live entries
    always_comb begin
        for (int i = 0; i < D; i++) begin
            n_q[i] = r_q[i];
            if (pop) n_q[i] = (i < D - 1) ? r_q[(i < D - 1) ? i + 1 : i] : r_q[i];
            if (i_wr_cnt != 2'd0 && CW'(i) == base) n_q[i] = i_d0;
            if (i_wr_cnt == 2'd2 && CW'(i) == base + CW'(1)) n_q[i] = i_d1;
        end
        n_cnt = base + CW'(i_wr_cnt);
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < D; i++) r_q[i] <= n_q[i];
        if (!i_rst_n) r_cnt <= '0;
        else r_cnt <= n_cnt;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(D)) else $error("queue overfilled");
    a_no_write_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr_cnt != 2'd0) |-> (base + CW'(i_wr_cnt) <= CW'(D)))
        else $error("write beyond queue depth");
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && i_wr_cnt == 2'd0) |=> (r_cnt == $past(r_cnt) - CW'(1)))
        else $error("read did not drain");

endmodule

### rtl/c_subset_lexer.sv
// c_subset_lexer: top level of the c subset lexer, state registers and position counters.
// Depends on clx_pkg, clx_step and clx_queue.
//
//  channel | valid / ready        | payload
//  source  | i_valid / o_ready    | i_src_byte, i_end_of_input
//  token   | o_valid / i_ready    | o_value_byte .. o_error_code
//
// one source word is taken per cycle while o_ready is high; its result words go
// to a four-entry queue the same cycle and leave it one word per cycle while i_ready
// o_ready needs two free queue entries, so a stalled token side holds off input
// synchronous active-low reset returns to line 1, column 0, between tokens
// after an error no word is produced until reset; after END each end mark repeats END
module c_subset_lexer #(
    parameter int LINE_BITS   = clx_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS = clx_pkg::COLUMN_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [7:0]             i_src_byte,
    input  logic                   i_end_of_input,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [7:0]             o_value_byte,
    output logic                   o_byte_valid,
    output logic [5:0]             o_token_kind,
    output logic [LINE_BITS-1:0]   o_start_line,
    output logic [COLUMN_BITS-1:0] o_start_column,
    output logic                   o_first_of_token,
    output logic                   o_last_of_token,
    output logic [2:0]             o_error_code
);

    localparam int RW = 8 + 1 + 6 + LINE_BITS + COLUMN_BITS + 1 + 1 + 3;

    clx_pkg::t_state        r_st;
    clx_pkg::t_state        n_st;
    clx_pkg::t_item         item0;
    clx_pkg::t_item         item1;
    logic [1:0]             cnt;
    logic                   set_tok;
    logic                   pos_step;
    logic                   acc;
    logic [LINE_BITS-1:0]   r_line;
    logic [COLUMN_BITS-1:0] r_col;
    logic [LINE_BITS-1:0]   r_tok_line;
    logic [COLUMN_BITS-1:0] r_tok_col;
    logic [RW-1:0]          d0;
    logic [RW-1:0]          d1;
    logic [RW-1:0]          q_data;
    logic [1:0]             wr_cnt;

    assign acc    = i_valid && o_ready;
    assign wr_cnt = acc ? cnt : 2'd0;

    clx_step u_step (
        .i_c        (i_src_byte),
        .i_eoi      (i_end_of_input),
        .i_st       (r_st),
        .o_st       (n_st),
        .o_item0    (item0),
        .o_item1    (item1),
        .o_cnt      (cnt),
        .o_set_tok  (set_tok),
        .o_pos_step (pos_step)
    );

    // pack words with their positions
    assign d0 = {item0.value, item0.bvalid, item0.kind,
                 item0.at_cur ? r_line : r_tok_line, item0.at_cur ? r_col : r_tok_col,
                 item0.first, item0.last, item0.err};
    assign d1 = {item1.value, item1.bvalid, item1.kind,
                 item1.at_cur ? r_line : r_tok_line, item1.at_cur ? r_col : r_tok_col,
                 item1.first, item1.last, item1.err};

    clx_queue #(.W(RW)) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_cnt (wr_cnt),
        .i_d0     (d0),
        .i_d1     (d1),
        .o_room   (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_data   (q_data)
    );

    assign {o_value_byte, o_byte_valid, o_token_kind, o_start_line, o_start_column,
            o_first_of_token, o_last_of_token, o_error_code} = q_data;

    // scanner state and saturating position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.mode  <= clx_pkg::M_IDLE;
            r_st.cand  <= '1;
            r_st.len   <= '0;
            r_st.hb    <= '0;
            r_st.hk    <= '0;
            r_st.hv    <= 1'b0;
            r_st.fp    <= 1'b0;
            r_st.opf   <= '0;
            r_line     <= LINE_BITS'(1);
            r_col      <= '0;
            r_tok_line <= LINE_BITS'(1);
            r_tok_col  <= '0;
        end else if (acc) begin
            r_st <= n_st;
            if (set_tok) begin
                r_tok_line <= r_line;
                r_tok_col  <= r_col;
            end
            if (pos_step) begin
                if (i_src_byte == 8'd10) begin
                    if (r_line != {LINE_BITS{1'b1}}) r_line <= r_line + LINE_BITS'(1);
                    r_col <= '0;
                end else if (r_col != {COLUMN_BITS{1'b1}}) begin
                    r_col <= r_col + COLUMN_BITS'(1);
                end
            end
        end
    end

    a_halt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.mode == clx_pkg::M_HALT) |-> (cnt == 2'd0)) else $error("word after halt");
    a_err_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && cnt != 2'd0 && item0.err != clx_pkg::E_NONE) |=>
        (r_st.mode == clx_pkg::M_HALT)) else $error("error did not halt");
    a_done_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.mode == clx_pkg::M_DONE) |-> !r_st.hv) else $error("held byte after end");

endmodule

### dv/tb_top.sv
// tb_top: self-checking testbench for the c subset lexer, with a token predictor,
// a directed stimulus table and random token streams.
// Depends on clx_pkg and c_subset_lexer.
module tb_top;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS   = 1550;

    // one token word as seen on the output channel
    typedef struct packed {
        logic [7:0]  value;
        logic        bvalid;
        logic [5:0]  kind;
        logic [15:0] line;
        logic [11:0] column;
        logic        first;
        logic        last;
        logic [2:0]  err;
    } tok_word_t;

    // directed stimulus row; typed rows carry their expected word
    typedef struct {
        logic [7:0] src;
        logic       eoi;
        bit         typed;
        tok_word_t  word;
    } lex_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_src_byte;
    logic        i_end_of_input;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_value_byte;
    logic        o_byte_valid;
    logic [5:0]  o_token_kind;
    logic [15:0] o_start_line;
    logic [11:0] o_start_column;
    logic        o_first_of_token;
    logic        o_last_of_token;
    logic [2:0]  o_error_code;

    c_subset_lexer uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_src_byte       (i_src_byte),
        .i_end_of_input   (i_end_of_input),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_value_byte     (o_value_byte),
        .o_byte_valid     (o_byte_valid),
        .o_token_kind     (o_token_kind),
        .o_start_line     (o_start_line),
        .o_start_column   (o_start_column),
        .o_first_of_token (o_first_of_token),
        .o_last_of_token  (o_last_of_token),
        .o_error_code     (o_error_code)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // predictor state
    tok_word_t   expected_words[$];
    logic [4:0]  scan;
    logic [20:0] kw_mask;
    int          name_len;
    logic [7:0]  held;
    logic [5:0]  held_k;
    bit          held_v;
    bit          first_due;
    logic [7:0]  op_lead;
    logic [15:0] tok_line;
    logic [11:0] tok_col;
    logic [15:0] cur_line;
    logic [11:0] cur_col;

    string kw_txt [21] = '{
        "static", "extern", "void", "char", "int", "long", "double", "unsigned",
        "struct", "return", "if", "else", "for", "while", "do", "continue",
        "break", "switch", "case", "default", "sizeof"
    };
    logic [5:0] kw_code [21] = '{
        6'd6, 6'd7, 6'd8, clx_pkg::K_CHAR, 6'd9, 6'd10, 6'd11, 6'd12, 6'd13, 6'd14,
        6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24,
        clx_pkg::K_OPER
    };

    // bookkeeping
    int n_sent;
    int n_words;
    int n_fail;
    int stall_cnt;
    int send_idle_pct;
    int recv_idle_pct;
    bit typed_row;
    tok_word_t typed_word;
    bit pressure_done;

    function void put_word(logic [7:0] v, bit bv, logic [5:0] k, logic [15:0] ln,
                           logic [11:0] cl, bit f, bit l, logic [2:0] e);
        tok_word_t w;
        w = '{v, bv, k, ln, cl, f, l, e};
        expected_words.push_back(w);
    endfunction

    function void open_tok(logic [5:0] k);
        held_k    = k;
        held_v    = 0;
        first_due = 1;
        tok_line  = cur_line;
        tok_col   = cur_col;
    endfunction

    function void push_val(logic [7:0] b);
        if (held_v) begin
            put_word(held, 1, held_k, tok_line, tok_col, first_due, 0, clx_pkg::E_NONE);
            first_due = 0;
        end
        held   = b;
        held_v = 1;
    endfunction

    function void close_tok(logic [5:0] k);
        if (held_v)
            put_word(held, 1, k, tok_line, tok_col, first_due, 1, clx_pkg::E_NONE);
        else
            put_word(8'd0, 0, k, tok_line, tok_col, 1, 1, clx_pkg::E_NONE);
        held_v    = 0;
        first_due = 0;
        scan      = clx_pkg::M_IDLE;
    endfunction

    function void raise_err(logic [2:0] code);
        held_v    = 0;
        first_due = 0;
        put_word(8'd0, 0, clx_pkg::K_END, cur_line, cur_col, 1, 1, code);
        scan = clx_pkg::M_HALT;
    endfunction

    function void emit_end();
        put_word(8'd0, 0, clx_pkg::K_END, cur_line, cur_col, 1, 1, clx_pkg::E_NONE);
        scan = clx_pkg::M_DONE;
    endfunction

    // decoded escape byte, -1 when the escape is not allowed
    function int esc_byte(logic [7:0] c);
        case (c)
            "\\": return 92;
            "'":  return 39;
            "\"": return 34;
            "n":  return 10;
            "r":  return 13;
            "t":  return 9;
            "b":  return 8;
            "f":  return 12;
            "v":  return 11;
            "a":  return 7;
            "0":  return 0;
            default: return -1;
        endcase
    endfunction

    function bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // narrow the keyword mask by one name byte
    function void name_add(logic [7:0] c);
        if (name_len >= 8) begin
            kw_mask = '0;
        end else begin
            for (int k = 0; k < 21; k++)
                if (kw_txt[k].len() <= name_len || kw_txt[k][name_len] != c)
                    kw_mask[k] = 1'b0;
        end
        if (name_len < 15) name_len++;
        push_val(c);
    endfunction

    function logic [5:0] name_kind();
        for (int k = 0; k < 21; k++)
            if (kw_mask[k] && kw_txt[k].len() == name_len) return kw_code[k];
        return clx_pkg::K_IDENT;
    endfunction

    function logic [5:0] punct_kind(logic [7:0] c);
        case (c)
            "(": return 6'd25;
            ")": return 6'd26;
            "[": return 6'd27;
            "]": return 6'd28;
            "{": return 6'd29;
            "}": return 6'd30;
            ",": return 6'd31;
            ";": return 6'd32;
            ":": return 6'd33;
            "#": return 6'd34;
            default: return clx_pkg::K_END;
        endcase
    endfunction

    function void start_tok(logic [7:0] c);
        logic [5:0] pk;
        if (c == " " || (c >= 9 && c <= 13)) return;
        if (is_digit(c)) begin
            open_tok(clx_pkg::K_NUMBER);
            push_val(c);
            scan = clx_pkg::M_NUMBER;
            return;
        end
        if (is_alpha(c) || c == "_") begin
            open_tok(clx_pkg::K_IDENT);
            kw_mask  = '1;
            name_len = 0;
            name_add(c);
            scan = clx_pkg::M_IDENT;
            return;
        end
        case (c)
            "/": begin
                open_tok(clx_pkg::K_OPER);
                push_val(c);
                scan = clx_pkg::M_SLASH;
                return;
            end
            "'": begin
                open_tok(clx_pkg::K_CHAR);
                scan = clx_pkg::M_CH_OPEN;
                return;
            end
            "\"": begin
                open_tok(clx_pkg::K_STRING);
                scan = clx_pkg::M_STR;
                return;
            end
            "\\": begin
                scan = clx_pkg::M_BSLASH;
                return;
            end
            "~", ".", "?": begin
                put_word(c, 1, clx_pkg::K_OPER, cur_line, cur_col, 1, 1, clx_pkg::E_NONE);
                return;
            end
            "*", "%", "^", "!", "=", "+", "&", "|", "-", "<", ">": begin
                open_tok(clx_pkg::K_OPER);
                push_val(c);
                op_lead = c;
                scan = clx_pkg::M_OP1;
                return;
            end
            default: ;
        endcase
        pk = punct_kind(c);
        if (pk != clx_pkg::K_END) put_word(c, 1, pk, cur_line, cur_col, 1, 1, clx_pkg::E_NONE);
        else raise_err(clx_pkg::E_UNKNOWN);
    endfunction

    // byte inside a token; returns 1 when the byte must start a new token
    function bit cont_tok(logic [7:0] c);
        int e;
        bit ext;
        ext = 0;
        case (scan)
            clx_pkg::M_IDENT: begin
                if (is_alpha(c) || is_digit(c) || c == "_") begin
                    name_add(c);
                    return 0;
                end
                close_tok(name_kind());
                return 1;
            end
            clx_pkg::M_NUMBER: begin
                if (is_digit(c)) begin
                    push_val(c);
                    return 0;
                end
                close_tok(clx_pkg::K_NUMBER);
                return 1;
            end
            clx_pkg::M_OP1: begin
                if (op_lead == "<" || op_lead == ">") begin
                    if (c == op_lead) begin
                        push_val(c);
                        scan = clx_pkg::M_OP2;
                        return 0;
                    end
                    ext = (c == "=");
                end else if (op_lead == "+" || op_lead == "&" || op_lead == "|") begin
                    ext = (c == op_lead || c == "=");
                end else if (op_lead == "-") begin
                    ext = (c == "-" || c == "=" || c == ">");
                end else begin
                    ext = (c == "=");
                end
                if (ext) begin
                    push_val(c);
                    close_tok(clx_pkg::K_OPER);
                    return 0;
                end
                close_tok(clx_pkg::K_OPER);
                return 1;
            end
            clx_pkg::M_OP2: begin
                if (c == "=") begin
                    push_val(c);
                    close_tok(clx_pkg::K_OPER);
                    return 0;
                end
                close_tok(clx_pkg::K_OPER);
                return 1;
            end
            clx_pkg::M_SLASH: begin
                if (c == "/" || c == "*") begin
                    held_v    = 0;
                    first_due = 0;
                    scan = (c == "/") ? clx_pkg::M_LCOMM : clx_pkg::M_BCOMM;
                    return 0;
                end
                if (c == "=") begin
                    push_val(c);
                    close_tok(clx_pkg::K_OPER);
                    return 0;
                end
                close_tok(clx_pkg::K_OPER);
                return 1;
            end
            clx_pkg::M_LCOMM: begin
                if (c == 8'd10) scan = clx_pkg::M_IDLE;
                return 0;
            end
            clx_pkg::M_BCOMM: begin
                if (c == "*") scan = clx_pkg::M_BSTAR;
                return 0;
            end
            clx_pkg::M_BSTAR: begin
                if (c == "/") scan = clx_pkg::M_IDLE;
                else if (c != "*") scan = clx_pkg::M_BCOMM;
                return 0;
            end
            clx_pkg::M_STR: begin
                if (c == "\"") close_tok(clx_pkg::K_STRING);
                else if (c == "\\") scan = clx_pkg::M_STR_ESC;
                else push_val(c);
                return 0;
            end
            clx_pkg::M_STR_ESC: begin
                if (c == 8'd10) begin
                    scan = clx_pkg::M_STR;
                    return 0;
                end
                e = esc_byte(c);
                if (e < 0) raise_err(clx_pkg::E_BAD_ESC);
                else begin
                    push_val(e[7:0]);
                    scan = clx_pkg::M_STR;
                end
                return 0;
            end
            clx_pkg::M_CH_OPEN: begin
                if (c == "\\") scan = clx_pkg::M_CH_ESC;
                else begin
                    push_val(c);
                    scan = clx_pkg::M_CH_CLOSE;
                end
                return 0;
            end
            clx_pkg::M_CH_ESC: begin
                if (c == 8'd10) begin
                    scan = clx_pkg::M_CH_OPEN;
                    return 0;
                end
                e = esc_byte(c);
                if (e < 0) raise_err(clx_pkg::E_BAD_ESC);
                else begin
                    push_val(e[7:0]);
                    scan = clx_pkg::M_CH_CLOSE;
                end
                return 0;
            end
            clx_pkg::M_CH_CLOSE: begin
                if (c == "'") close_tok(clx_pkg::K_CHAR);
                else raise_err(clx_pkg::E_NO_CLOSE);
                return 0;
            end
            clx_pkg::M_BSLASH: begin
                if (c == 8'd10) scan = clx_pkg::M_IDLE;
                else raise_err(clx_pkg::E_STRAY_BS);
                return 0;
            end
            default: begin
                scan = clx_pkg::M_IDLE;
                return 1;
            end
        endcase
    endfunction

    function void end_of_file();
        case (scan)
            clx_pkg::M_IDENT: begin
                close_tok(name_kind());
                emit_end();
            end
            clx_pkg::M_NUMBER: begin
                close_tok(clx_pkg::K_NUMBER);
                emit_end();
            end
            clx_pkg::M_OP1, clx_pkg::M_OP2, clx_pkg::M_SLASH: begin
                close_tok(clx_pkg::K_OPER);
                emit_end();
            end
            clx_pkg::M_BCOMM, clx_pkg::M_BSTAR: raise_err(clx_pkg::E_OPEN_CMT);
            clx_pkg::M_STR, clx_pkg::M_STR_ESC: raise_err(clx_pkg::E_OPEN_STR);
            clx_pkg::M_CH_OPEN, clx_pkg::M_CH_ESC, clx_pkg::M_CH_CLOSE:
                raise_err(clx_pkg::E_NO_CLOSE);
            clx_pkg::M_BSLASH: raise_err(clx_pkg::E_STRAY_BS);
            default: emit_end();
        endcase
    endfunction

    // expected token words for one accepted source word
    function void lex_predict(logic [7:0] c, logic eoi);
        if (scan == clx_pkg::M_HALT) return;
        if (scan == clx_pkg::M_DONE) begin
            if (eoi) emit_end();
            return;
        end
        if (eoi) begin
            end_of_file();
            return;
        end
        if (scan == clx_pkg::M_IDLE || cont_tok(c)) start_tok(c);
        if (c == 8'd10) begin
            if (cur_line != 16'hFFFF) cur_line++;
            cur_col = '0;
        end else if (cur_col != 12'hFFF) begin
            cur_col++;
        end
    endfunction

    // source side: run the predictor on every accepted word
    always @(posedge i_clk) begin
        int n0;
        if (i_rst_n && i_valid && o_ready) begin
            n0 = expected_words.size();
            lex_predict(i_src_byte, i_end_of_input);
            if (typed_row) begin
                while (expected_words.size() > n0) void'(expected_words.pop_back());
                expected_words.push_back(typed_word);
            end
            n_sent++;
        end
    end

    task automatic chk_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endtask

    // token side: compare each accepted word with the oldest expectation
    always @(posedge i_clk) begin
        tok_word_t w;
        if (i_rst_n && o_valid && i_ready) begin
            n_words++;
            if (expected_words.size() == 0) begin
                $error("token word with no expectation pending");
                n_fail++;
            end else begin
                w = expected_words.pop_front();
                chk_field("value_byte", w.value, o_value_byte);
                chk_field("byte_valid", w.bvalid, o_byte_valid);
                chk_field("token_kind", w.kind, o_token_kind);
                chk_field("start_line", w.line, o_start_line);
                chk_field("start_column", w.column, o_start_column);
                chk_field("first_of_token", w.first, o_first_of_token);
                chk_field("last_of_token", w.last, o_last_of_token);
                chk_field("error_code", w.err, o_error_code);
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    // token side ready, with one long hold-off once input is flowing
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!pressure_done && n_sent >= 300) begin
                pressure_done = 1;
                i_ready = 1'b0;
                repeat (400) @(negedge i_clk);
            end
            i_ready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // pick the idling phase from the running word count
    function void set_phase();
        case ((n_sent / 150) % 4)
            0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            1: begin send_idle_pct = 73; recv_idle_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_idle_pct = 73; end
            default: begin send_idle_pct = 6; recv_idle_pct = 6; end
        endcase
    endfunction

    // offer one source word, called at a falling edge and returning at one
    task automatic send_word(logic [7:0] b, logic eoi);
        set_phase();
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid    = 1'b0;
            i_src_byte = $urandom_range(0, 255);
            @(negedge i_clk);
        end
        i_valid        = 1'b1;
        i_src_byte     = b;
        i_end_of_input = eoi;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        i_valid        = 1'b0;
        i_end_of_input = 1'b0;
    endtask

    logic [7:0] src_q[$];

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) src_q.push_back(s[i]);
    endtask

    // one random well-formed snippet followed by whitespace
    task automatic gen_snippet();
        string ops [24] = '{
            "<<=", ">>=", "<<", ">>", "<=", ">=", "->", "--", "-=", "++", "+=",
            "&&", "&=", "||", "|=", "!=", "==", "*=", "%=", "^=", "/=", "/",
            "~", "?"
        };
        string single_ops = "<>-+&|!=*%^.";
        string puncts = "()[]{},;:#";
        string escs = "\\'\"nrtbfva0";
        string id_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
        int n;
        logic [7:0] b;
        case ($urandom_range(0, 11))
            0, 1: begin
                n = $urandom_range(1, 18);
                src_q.push_back(id_chars[$urandom_range(0, 52)]);
                for (int i = 1; i < n; i++) src_q.push_back(id_chars[$urandom_range(0, 62)]);
            end
            2, 3: begin
                add_text(kw_txt[$urandom_range(0, 20)]);
                if ($urandom_range(0, 4) == 0) src_q.push_back(id_chars[$urandom_range(0, 62)]);
            end
            4: begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++) src_q.push_back($urandom_range(48, 57));
            end
            5: begin
                if ($urandom_range(0, 1)) add_text(ops[$urandom_range(0, 23)]);
                else src_q.push_back(single_ops[$urandom_range(0, single_ops.len() - 1)]);
            end
            6: src_q.push_back(puncts[$urandom_range(0, 9)]);
            7: begin
                src_q.push_back("\"");
                n = $urandom_range(0, 6);
                for (int i = 0; i < n; i++) begin
                    case ($urandom_range(0, 5))
                        0: begin
                            src_q.push_back("\\");
                            src_q.push_back(escs[$urandom_range(0, 10)]);
                        end
                        1: add_text("\\\n");
                        2: src_q.push_back(8'd10);
                        default: begin
                            do b = $urandom_range(0, 255); while (b == "\"" || b == "\\");
                            src_q.push_back(b);
                        end
                    endcase
                end
                src_q.push_back("\"");
            end
            8: begin
                src_q.push_back("'");
                if ($urandom_range(0, 3) == 0) add_text("\\\n");
                if ($urandom_range(0, 2) == 0) begin
                    src_q.push_back("\\");
                    src_q.push_back(escs[$urandom_range(0, 10)]);
                end else begin
                    do b = $urandom_range(0, 255); while (b == "\\");
                    src_q.push_back(b);
                end
                src_q.push_back("'");
            end
            9: begin
                add_text("//");
                n = $urandom_range(0, 8);
                for (int i = 0; i < n; i++) begin
                    do b = $urandom_range(0, 255); while (b == 8'd10);
                    src_q.push_back(b);
                end
                src_q.push_back(8'd10);
            end
            10: begin
                add_text("/*");
                n = $urandom_range(0, 8);
                for (int i = 0; i < n; i++) begin
                    do b = $urandom_range(0, 255); while (b == "/");
                    src_q.push_back(b);
                end
                add_text("*/");
            end
            default: add_text("\\\n");
        endcase
        case ($urandom_range(0, 4))
            0: src_q.push_back(8'd10);
            1: src_q.push_back($urandom_range(9, 13));
            default: src_q.push_back(" ");
        endcase
    endtask

    function lex_row_t row(logic [7:0] c, bit t = 0, logic [7:0] v = 0, bit bv = 0,
                           logic [5:0] k = 0, logic [11:0] cl = 0);
        lex_row_t r;
        r.src   = c;
        r.eoi   = 1'b0;
        r.typed = t;
        r.word  = '{v, bv, k, 16'd1, cl, 1'b1, 1'b1, clx_pkg::E_NONE};
        return r;
    endfunction

    // stimulus
    initial begin
        lex_row_t dir_rows[$];
        int n_random;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_src_byte     = 8'd0;
        i_end_of_input = 1'b0;
        n_sent = 0;
        n_words = 0;
        n_fail = 0;
        stall_cnt = 0;
        typed_row = 0;
        pressure_done = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        scan = clx_pkg::M_IDLE;
        kw_mask = '1;
        name_len = 0;
        held = 0;
        held_k = 0;
        held_v = 0;
        first_due = 0;
        op_lead = 0;
        tok_line = 1;
        tok_col = 0;
        cur_line = 1;
        cur_col = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table: punctuation, shift-assign, char escape, empty string,
        // comments and the sizeof keyword
        dir_rows = '{
            row("(", 1, "(", 1, 6'd25, 0), row(")", 1, ")", 1, 6'd26, 1),
            row("<"), row("<"), row("="),
            row("'"), row("\\"), row("n"), row("'"),
            row("\""), row("\"", 1, 0, 0, clx_pkg::K_STRING, 9),
            row("/"), row("/"), row(8'd10),
            row("/"), row("*"), row("*"), row("/"),
            row("s"), row("i"), row("z"), row("e"), row("o"), row("f"), row(8'd10)
        };
        foreach (dir_rows[i]) begin
            typed_row  = dir_rows[i].typed;
            typed_word = dir_rows[i].word;
            send_word(dir_rows[i].src, dir_rows[i].eoi);
        end
        typed_row = 0;

        // random token streams
        n_random = 0;
        while (n_random < RANDOM_ITEMS) begin
            gen_snippet();
            while (src_q.size() > 0) begin
                send_word(src_q.pop_front(), 1'b0);
                n_random++;
            end
        end

        // end of input, ignored bytes, repeated end
        send_word($urandom_range(0, 255), 1'b1);
        repeat (3) send_word($urandom_range(128, 255), 1'b0);
        send_word($urandom_range(0, 255), 1'b1);

        while (expected_words.size() > 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        $display("lexer run: %0d source words, %0d token words, random snippets,",
                 n_sent, n_words);
        $display("idle and stall phases, end of input and repeated end");
        if (n_fail == 0 && expected_words.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### c_subset_lexer.f
rtl/clx_pkg.sv
rtl/clx_step.sv
rtl/clx_queue.sv
rtl/c_subset_lexer.sv
dv/tb_top.sv
